@@ src/tcw_pkg.sv @@
// ============================================================================
// tcw_pkg - shared types and constants of the text console writer
// Opcodes, beat payload structs and the default geometry of the screen.
// ============================================================================
package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    // Character code that moves the cursor to the next row
    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // Reset value of the default attribute register
    localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;

    // Width of the reported cursor cell index
    localparam int CURSOR_W = 11;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    // One input beat
    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  char_code;
        logic [7:0]  attribute;
        logic        use_cursor;
        logic [4:0]  row;
        logic [6:0]  col;
    } t_item;

    // One result beat
    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_cell;
        logic                scrolled;
        logic [7:0]          read_char;
        logic [7:0]          read_attribute;
    } t_result;

endpackage

@@ src/tcw_in_if.sv @@
// ============================================================================
// tcw_in_if - input channel of the text console writer
// Valid/ready channel carrying one console operation per beat.
// ============================================================================
interface tcw_in_if;
    import tcw_pkg::*;

    logic       valid;
    logic       ready;
    t_opcode    opcode;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic       use_cursor;
    logic [4:0] row;
    logic [6:0] col;

    modport source (
        output valid, opcode, char_code, attribute, use_cursor, row, col,
        input  ready
    );

    modport sink (
        input  valid, opcode, char_code, attribute, use_cursor, row, col,
        output ready
    );
endinterface

@@ src/tcw_out_if.sv @@
// ============================================================================
// tcw_out_if - result channel of the text console writer
// Valid/ready channel carrying one operation result per beat.
// ============================================================================
interface tcw_out_if;
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [CURSOR_W-1:0] cursor_cell;
    logic                scrolled;
    logic [7:0]          read_char;
    logic [7:0]          read_attribute;

    modport source (
        output valid, cursor_cell, scrolled, read_char, read_attribute,
        input  ready
    );

    modport sink (
        input  valid, cursor_cell, scrolled, read_char, read_attribute,
        output ready
    );
endinterface

@@ src/tcw_cell_ram.sv @@
// ============================================================================
// tcw_cell_ram - screen cell store
// One write port and one read port; read data is registered.
// ============================================================================
module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write one cell
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one cell, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/tcw_ctrl.sv @@
// ============================================================================
// tcw_ctrl - sequencer of the text console writer
// Runs put, read, clear and scroll against the cell store and keeps the cursor.
// ============================================================================
module tcw_ctrl #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT,
    parameter int CELLS   = ROWS * COLUMNS,
    parameter int AW      = $clog2(CELLS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tcw_pkg::t_item   i_item,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output tcw_pkg::t_result o_res,
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output logic [15:0]      o_mem_wdata,
    output logic [AW-1:0]    o_mem_raddr,
    input  logic [15:0]      i_mem_rdata
);
    import tcw_pkg::*;

    localparam int CW  = $clog2(CELLS + 1);
    localparam int RW  = $clog2(ROWS);
    localparam int CLW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    localparam logic [AW-1:0]  LAST_ROW  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0]  LAST_CELL = AW'(CELLS - 1);
    localparam logic [CW-1:0]  CELLS_C   = CW'(CELLS);
    localparam logic [CW-1:0]  COLS_C    = CW'(COLUMNS);
    localparam logic [CLW:0]   COLS_X    = (CLW + 1)'(COLUMNS);
    localparam logic [AW-1:0]  COLS_A    = AW'(COLUMNS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_COPY,
        S_FILL,
        S_DONE
    } t_state;

    t_state         r_state;
    t_item          r_item;
    logic [RW-1:0]  r_row_sat;
    logic [CLW-1:0] r_col_sat;
    logic [AW-1:0]  r_cur;
    logic [CLW-1:0] r_cur_col;
    logic [7:0]     r_def_attr;
    logic [CW-1:0]  r_src;
    logic [AW-1:0]  r_dst;
    logic           r_cp_v;
    logic [AW-1:0]  r_fill;
    logic           r_fill_report;
    t_result        r_res;

    logic           in_accept;
    logic [7:0]     row_ext;
    logic [8:0]     col_ext;
    logic [RW-1:0]  row_sat;
    logic [CLW-1:0] col_sat;
    logic [AW-1:0]  pos_grid;
    logic [AW-1:0]  pos;
    logic [CLW-1:0] pos_col;
    logic           is_nl;
    logic [CW-1:0]  next_cell;
    logic [CLW:0]   col_inc;
    logic           scroll;
    logic [AW-1:0]  n_cur;
    logic [CLW-1:0] n_col;
    logic [7:0]     attr_eff;

    // Take a beat when idle, or when the finished result leaves this cycle
    assign o_in_ready  = (r_state == S_IDLE) || ((r_state == S_DONE) && i_res_ready);
    assign in_accept   = o_in_ready && i_in_valid;
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    // Saturate row and column of the incoming beat
    assign row_ext = {3'b000, i_item.row};
    assign col_ext = {2'b00, i_item.col};
    assign row_sat = (row_ext >= 8'(ROWS))    ? RW'(ROWS - 1)     : RW'(i_item.row);
    assign col_sat = (col_ext >= 9'(COLUMNS)) ? CLW'(COLUMNS - 1) : CLW'(i_item.col);

    // Target cell and cursor advance of a put
    assign pos_grid = AW'(r_row_sat) * COLS_A + AW'(r_col_sat);
    assign pos      = r_item.use_cursor ? r_cur : pos_grid;
    assign pos_col  = r_item.use_cursor ? r_cur_col : r_col_sat;
    assign is_nl    = (r_item.char_code == NEWLINE_CODE);
    assign next_cell = is_nl ? (CW'(pos) + COLS_C - CW'(pos_col)) : (CW'(pos) + CW'(1));
    assign col_inc  = {1'b0, pos_col} + (CLW + 1)'(1);
    assign scroll   = (next_cell >= CELLS_C);
    assign n_cur    = scroll ? LAST_ROW : AW'(next_cell);
    assign n_col    = (scroll || is_nl || (col_inc == COLS_X)) ? '0 : col_inc[CLW-1:0];
    assign attr_eff = (r_item.attribute == 8'd0) ? r_def_attr : r_item.attribute;

    // Steer the memory ports by phase; a read addresses row and column, but the row shift reads its source pointer
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = pos;
        o_mem_wdata = {attr_eff, r_item.char_code};
        o_mem_raddr = pos_grid;
        case (r_state)
            S_EXEC: begin
                o_mem_we = (r_item.opcode == OP_PUT) && !is_nl;
            end
            S_COPY: begin
                o_mem_we    = r_cp_v;
                o_mem_waddr = r_dst;
                o_mem_wdata = i_mem_rdata;
                o_mem_raddr = r_src[AW-1:0];
            end
            S_FILL: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_fill;
                o_mem_wdata = '0;
            end
            default: begin
            end
        endcase
    end

    // Sequencer: hold state, cursor and the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_FILL;
            r_fill        <= '0;
            r_fill_report <= 1'b0;
            r_cur         <= '0;
            r_cur_col     <= '0;
            r_def_attr    <= DEFAULT_ATTR_RESET;
            r_cp_v        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_def_attr <= i_cfg_wr_data;
            end
            r_cp_v <= 1'b0;
            if (in_accept) begin
                r_item    <= i_item;
                r_row_sat <= row_sat;
                r_col_sat <= col_sat;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res.cursor_cell    <= CURSOR_W'(r_cur);
                    r_res.scrolled       <= 1'b0;
                    r_res.read_char      <= '0;
                    r_res.read_attribute <= '0;
                    r_state              <= S_DONE;
                    case (r_item.opcode)
                        OP_PUT: begin
                            r_cur             <= n_cur;
                            r_cur_col         <= n_col;
                            r_res.cursor_cell <= CURSOR_W'(n_cur);
                            r_res.scrolled    <= scroll;
                            if (scroll) begin
                                r_src   <= COLS_C;
                                r_state <= S_COPY;
                            end
                        end
                        OP_CLEAR: begin
                            r_cur             <= '0;
                            r_cur_col         <= '0;
                            r_res.cursor_cell <= '0;
                            r_fill            <= '0;
                            r_fill_report     <= 1'b1;
                            r_state           <= S_FILL;
                        end
                        OP_READ: begin
                            r_state <= S_RDWAIT;
                        end
                        default: begin
                        end
                    endcase
                end
                S_RDWAIT: begin
                    r_res.read_char      <= i_mem_rdata[7:0];
                    r_res.read_attribute <= i_mem_rdata[15:8];
                    r_state              <= S_DONE;
                end
                // Shift rows up: read one row ahead, write back in the following cycle
                S_COPY: begin
                    if (r_src == CELLS_C) begin
                        r_fill        <= LAST_ROW;
                        r_fill_report <= 1'b1;
                        r_state       <= S_FILL;
                    end else begin
                        r_src  <= r_src + CW'(1);
                        r_dst  <= AW'(r_src - COLS_C);
                        r_cp_v <= 1'b1;
                    end
                end
                // Zero cells up to the end of the store
                S_FILL: begin
                    r_fill <= r_fill + AW'(1);
                    if (r_fill == LAST_CELL) begin
                        r_state <= r_fill_report ? S_DONE : S_IDLE;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= i_in_valid ? S_EXEC : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Cursor stays inside the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur <= LAST_CELL) && (CW'(r_cur_col) < COLS_C))
    else $error("cursor outside the screen");

    // A scrolled result leaves the cursor at the start of the last row
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_res.scrolled) |-> (r_cur == LAST_ROW) && (r_cur_col == '0))
    else $error("cursor not at last row after scroll");

    // The row shift hands over to zeroing of the last row
    a_copy_to_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_COPY) && (r_src == CELLS_C)) |=>
            ((r_state == S_FILL) && (r_fill == LAST_ROW)))
    else $error("row shift did not hand over to last row clear");

    // Copy writes always land one row and one cell before the read pointer
    a_copy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_COPY) && r_cp_v) |-> (CW'(r_dst) + COLS_C + CW'(1) == r_src))
    else $error("copy write out of step with read");
`endif
endmodule

@@ src/text_console_writer_unit.sv @@
// ============================================================================
// text_console_writer_unit - text-mode console engine
// Cell store with cursor; put, clear and read operations; scroll on overflow.
// ============================================================================
// A put or no-op passes through the execute and done states into the output register;
// a read adds a wait state for the registered RAM port. A new beat is taken as the
// previous result leaves the done state. A scroll adds a row shift plus a clear of
// the last row; a clear zeroes every cell of the store.
// Reset: synchronous; a clearing pass zeroes the store, and no beat is taken meanwhile
// while configuration writes still land.
module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    tcw_in_if.sink     i_in,
    tcw_out_if.source  o_out
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    t_item         item;
    t_result       res;
    logic          res_valid;
    logic          res_ready;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   mem_rdata;
    logic          r_out_valid;
    t_result       r_out;

    assign item = '{
        opcode:     i_in.opcode,
        char_code:  i_in.char_code,
        attribute:  i_in.attribute,
        use_cursor: i_in.use_cursor,
        row:        i_in.row,
        col:        i_in.col
    };

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CELLS   (CELLS),
        .AW      (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in.valid),
        .o_in_ready    (i_in.ready),
        .i_item        (item),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (16)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: take a result beat when empty or being drained
    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
            if (res_valid) begin
                r_out <= res;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.cursor_cell    = r_out.cursor_cell;
    assign o_out.scrolled       = r_out.scrolled;
    assign o_out.read_char      = r_out.read_char;
    assign o_out.read_attribute = r_out.read_attribute;
endmodule
